@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/hsl_pkg.sv @@
package hsl_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_HUE_SHIFT = 1'b0;
    localparam logic [0:0] CFG_SAT_OFFSET = 1'b1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    // Code of the max channel
    localparam logic [1:0] MAX_RED = 2'd0;
    localparam logic [1:0] MAX_GREEN = 2'd1;
    localparam logic [1:0] MAX_BLUE = 2'd2;

endpackage

@@ src/hsl_div.sv @@
// Pipelined restoring divider: quotient = floor(num / den), one bit per stage.
module hsl_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);
    logic [NUM_W:0]     valid_reg;
    logic [NUM_W-1:0]   num_reg [NUM_W+1];
    logic [DEN_W:0]     rem_reg [NUM_W+1];
    logic [DEN_W-1:0]   den_reg [NUM_W+1];
    logic [TAG_W-1:0]   tag_reg [NUM_W+1];

    always_comb
    begin
        num_reg[0] = num;
        rem_reg[0] = '0;
        den_reg[0] = den;
        tag_reg[0] = tag_in;
    end

    // Stage 0 is the input, stage NUM_W the output
    assign valid_reg[0] = in_valid;

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W+1:0] trial;
        logic [DEN_W:0]   shifted;
        logic             v_reg;
        logic [NUM_W-1:0] n_reg;
        logic [DEN_W:0]   r_reg;
        logic [DEN_W-1:0] d_reg;
        logic [TAG_W-1:0] t_reg;

        always_comb
        begin
            shifted = {rem_reg[s][DEN_W-1:0], num_reg[s][NUM_W-1]};
            trial = {1'b0, shifted} - {2'b00, den_reg[s]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            d_reg <= den_reg[s];
            t_reg <= tag_reg[s];
            if (!trial[DEN_W+1])
            begin
                r_reg <= trial[DEN_W:0];
                n_reg <= {num_reg[s][NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                n_reg <= {num_reg[s][NUM_W-2:0], 1'b0};
            end
        end

        assign valid_reg[s+1] = v_reg;
        assign num_reg[s+1] = n_reg;
        assign rem_reg[s+1] = r_reg;
        assign den_reg[s+1] = d_reg;
        assign tag_reg[s+1] = t_reg;
    end

    assign out_valid = valid_reg[NUM_W];
    assign quo = num_reg[NUM_W];
    assign tag_out = tag_reg[NUM_W];
endmodule

@@ src/hsl_front.sv @@
// Front: min/max classification, lightness, then divides for S and H.
module hsl_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  hsl_pkg::pixel_in_t    pix,
    output logic                  out_valid,
    output logic [FRAC_BITS:0]    lq,
    output logic [FRAC_BITS:0]    sq,
    output logic [FRAC_BITS-1:0]  hq,
    output logic                  gray
);
    localparam int ONE = 1 << FRAC_BITS;
    localparam int HNUM_W = 11 + FRAC_BITS;
    localparam int TAG_W = 1 + FRAC_BITS + 1;

    logic [7:0] r, g, b, mx, mn;
    logic [7:0] d;
    logic [8:0] sum;
    logic [7:0] den_s;
    logic [10:0] hn, d6;

    // Classification of the pixel
    always_comb
    begin
        r = pix.red_in;
        g = pix.green_in;
        b = pix.blue_in;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        den_s = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
        if (mx == r)
            hn = (g >= b) ? 11'({3'b0, g} - {3'b0, b})
                          : 11'(11'd6 * {3'b0, d} + {3'b0, g} - {3'b0, b});
        else if (mx == g)
            hn = 11'(11'd2 * {3'b0, d} + {3'b0, b} - {3'b0, r});
        else
            hn = 11'(11'd4 * {3'b0, d} + {3'b0, r} - {3'b0, g});
        d6 = 11'd6 * {3'b0, d};
    end

    // L = floor(sum*ONE/510) by reciprocal multiplication, exact for sum up to 510
    localparam int LK_SH = 18;
    localparam longint LK = ((longint'(1) << (FRAC_BITS + LK_SH)) + 509) / 510;
    localparam int LK_W = FRAC_BITS + 10;
    logic [LK_W+8:0]    lprod;
    logic [FRAC_BITS:0] lq_now;
    assign lprod = (LK_W+9)'(sum) * (LK_W+9)'(LK);
    assign lq_now = lprod[FRAC_BITS+LK_SH:LK_SH];

    // Numerators for the S and H divides
    logic [FRAC_BITS+8:0] snum;
    logic [HNUM_W-1:0]    hnum;
    assign snum = (FRAC_BITS+9)'(d) << FRAC_BITS;
    assign hnum = HNUM_W'(hn) << FRAC_BITS;

    logic               sv, hv;
    logic [FRAC_BITS+8:0] squo;
    logic [HNUM_W-1:0]  hquo;
    logic [0:0]         sg, hg;

    // Guard zero divisors for gray pixels; result is discarded
    hsl_div #(.NUM_W(FRAC_BITS+9), .DEN_W(8), .TAG_W(1)) u_sdiv (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .num(snum),
        .den((d == 8'd0) ? 8'd1 : den_s), .tag_in(d == 8'd0),
        .out_valid(sv), .quo(squo), .tag_out(sg)
    );

    hsl_div #(.NUM_W(HNUM_W), .DEN_W(11), .TAG_W(1)) u_hdiv (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .num(hnum),
        .den((d == 8'd0) ? 11'd1 : d6), .tag_in(d == 8'd0),
        .out_valid(hv), .quo(hquo), .tag_out(hg)
    );

    // The hue divider is the deepest path; delay S and L to match it
    localparam int MAXD = HNUM_W;
    localparam int DS = MAXD - (FRAC_BITS + 9);
    localparam int DH = MAXD - HNUM_W;
    localparam int DL = MAXD;

    logic [FRAC_BITS:0]   s_al [DS+1];
    logic [FRAC_BITS-1:0] h_al [DH+1];
    logic [FRAC_BITS:0]   l_al [DL+1];
    logic                 g_al [DS+1];
    logic                 v_al [DS+1];

    assign s_al[0] = squo[FRAC_BITS:0];
    assign g_al[0] = sg[0];
    assign v_al[0] = sv;
    assign h_al[0] = hquo[FRAC_BITS-1:0];
    assign l_al[0] = lq_now;

    for (genvar i = 0; i < DS; i++)
    begin : g_sdly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_al[i+1] <= 1'b0;
            else
                v_al[i+1] <= v_al[i];
        end
        always_ff @(posedge clk)
        begin
            s_al[i+1] <= s_al[i];
            g_al[i+1] <= g_al[i];
        end
    end
    for (genvar i = 0; i < DH; i++)
    begin : g_hdly
        always_ff @(posedge clk)
            h_al[i+1] <= h_al[i];
    end
    for (genvar i = 0; i < DL; i++)
    begin : g_ldly
        always_ff @(posedge clk)
            l_al[i+1] <= l_al[i];
    end

    assign out_valid = v_al[DS];
    assign gray = g_al[DS];
    assign sq = gray ? '0 : s_al[DS];
    assign hq = gray ? '0 : h_al[DH];
    assign lq = l_al[DL];

    logic unused_ok;
    assign unused_ok = ^{hv, hg, squo, hquo} | (ONE == 0);
endmodule

@@ src/hsl_fifo.sv @@
// Short register queue between front and back.
module hsl_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = $clog2(DEPTH);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    assign not_empty = (cnt_reg != '0);
    assign rdata = mem_reg[rd_reg];
endmodule

@@ src/hsl_back.sv @@
`include "assert_macros.svh"
// Back: adjust H and S, rebuild chroma, X, m and the three channels.
module hsl_back #(
    parameter int FRAC_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [FRAC_BITS:0]    lq,
    input  logic [FRAC_BITS:0]    sq,
    input  logic [FRAC_BITS-1:0]  hq,
    input  logic [11:0]           hue_shift,
    input  logic signed [13:0]    sat_offset,
    output logic                  done,
    output hsl_pkg::pixel_out_t   result
);
    localparam int F = FRAC_BITS;
    localparam logic [F+1:0] ONE = (F+2)'(1) << F;

    // Stage 1: rescale registers, hue wrap, saturation clamp, t
    logic [F-1:0]      shift;
    logic signed [F+2:0] soff;
    logic signed [F+3:0] ssum;
    logic [F:0]        s_cl;
    logic signed [F+3:0] two_l_m;
    logic [F:0]        t;
    logic [F-1:0]      h_adj;
    logic [11+F:0]     sh_full;
    logic signed [14+F:0] so_full, so_abs;

    always_comb
    begin
        sh_full = (12+F)'(hue_shift) << F;
        shift = sh_full[11+F:12];
        so_full = (15+F)'(sat_offset) <<< F;
        so_abs = so_full[14+F] ? -so_full : so_full;
        soff = so_full[14+F] ? -(F+3)'(so_abs >>> 12) : (F+3)'(so_abs >>> 12);
        h_adj = hq + shift;
        ssum = (F+4)'(signed'({1'b0, sq})) + (F+4)'(soff);
        if (ssum < 0)
            s_cl = '0;
        else if (ssum > signed'((F+4)'(ONE)))
            s_cl = ONE[F:0];
        else
            s_cl = ssum[F:0];
        two_l_m = signed'((F+4)'({lq, 1'b0})) - signed'((F+4)'(ONE));
        t = (F+1)'(ONE - (F+2)'(two_l_m < 0 ? -two_l_m : two_l_m));
    end

    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic [F:0]     t1_reg, s1_reg, l1_reg, l2_reg, l3_reg;
    logic [F-1:0]   h1_reg;

    // Stage 2: chroma multiply; hue sector and ramp
    logic [2*F+1:0] cprod;
    logic [F+3:0]   h6;
    logic [2:0]     sector;
    logic [F:0]     hm;
    logic signed [F+2:0] hmo;
    logic [F:0]     u;
    always_comb
    begin
        cprod = t1_reg * s1_reg;
        h6 = (F+4)'(h1_reg) * (F+4)'(6);
        sector = h6[F+2:F];
        hm = h6[F:0];
        hmo = signed'((F+3)'(hm)) - signed'((F+3)'(ONE));
        u = (F+1)'(ONE - (F+2)'(hmo < 0 ? -hmo : hmo));
    end

    logic [F:0] c2_reg, u2_reg;
    logic [2:0] sec2_reg;

    // Stage 3: X multiply
    logic [2*F+1:0] xprod;
    assign xprod = c2_reg * u2_reg;
    logic [F:0] c3_reg, x3_reg;
    logic [2:0] sec3_reg;

    // Stage 4: sector mux and channel scaling
    logic [F:0] rc, gc, bc;
    logic [F+2:0] m2;
    always_comb
    begin
        rc = '0;
        gc = '0;
        bc = '0;
        unique case (sec3_reg)
            3'd0:
            begin
                rc = c3_reg;
                gc = x3_reg;
            end
            3'd1:
            begin
                rc = x3_reg;
                gc = c3_reg;
            end
            3'd2:
            begin
                gc = c3_reg;
                bc = x3_reg;
            end
            3'd3:
            begin
                gc = x3_reg;
                bc = c3_reg;
            end
            3'd4:
            begin
                rc = x3_reg;
                bc = c3_reg;
            end
            default:
            begin
                rc = c3_reg;
                bc = x3_reg;
            end
        endcase
        m2 = (F+3)'({l3_reg, 1'b0}) - (F+3)'(c3_reg);
    end

    function automatic logic [7:0] to_chan(input logic [F:0] comp, input logic [F+2:0] mm);
        logic [F+3:0] s;
        logic [F+11:0] v;
        logic [F+11:0] q;
        begin
            s = (F+4)'({comp, 1'b0}) + (F+4)'(mm);
            v = (F+12)'(s) * (F+12)'(255);
            q = v >> (F + 1);
            to_chan = (q > (F+12)'(255)) ? 8'd255 : q[7:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= t;
        s1_reg <= s_cl;
        h1_reg <= h_adj;
        l1_reg <= lq;
        c2_reg <= cprod[2*F:F];
        u2_reg <= u;
        sec2_reg <= sector;
        l2_reg <= l1_reg;
        c3_reg <= c2_reg;
        x3_reg <= xprod[2*F:F];
        sec3_reg <= sec2_reg;
        l3_reg <= l2_reg;
        result.red_out <= to_chan(rc, m2);
        result.green_out <= to_chan(gc, m2);
        result.blue_out <= to_chan(bc, m2);
    end

    assign done = v4_reg;

    `ASSERT_NEXT(a_pipe_v, clk, rst_n, v1_reg, v2_reg, "back valid lost")
    `ASSERT_IMP(a_sector, clk, rst_n, v3_reg, sec3_reg < 3'd6, "bad hue sector")
    `ASSERT_IMP(a_x_le_c, clk, rst_n, v3_reg, x3_reg <= c3_reg, "X above chroma")
endmodule

@@ src/hsl_hue_saturation_adjust_unit.sv @@
`include "assert_macros.svh"
// Channel   Handshake           Payload
// pixel     start / busy        pixel_in (red_in, green_in, blue_in)
// result    done strobe         pixel_out (red_out, green_out, blue_out)
// config    cfg_valid/cfg_ready cfg_index, cfg_data
// One pixel accepted per clock; busy stays low. A request passes through the hue
// divider (FRAC_BITS+11 stages), the queue and 4 back stages to its result.
// Reset clears valid bits and the configuration registers to 0.
// The result cannot be stalled; the queue never backs up.
module hsl_hue_saturation_adjust_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  hsl_pkg::pixel_in_t    pixel_in,
    output logic                  done,
    output hsl_pkg::pixel_out_t   pixel_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hsl_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int QW = 3 * FRAC_BITS + 2;

    logic [11:0]        hue_reg;
    logic signed [13:0] sat_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
            sat_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == {1'b0, hsl_pkg::CFG_HUE_SHIFT})
                hue_reg <= cfg_data[11:0];
            else if (cfg_index == {1'b0, hsl_pkg::CFG_SAT_OFFSET})
                sat_reg <= signed'(cfg_data);
        end
    end
    assign cfg_ready = 1'b1;
    assign busy = 1'b0;

    logic                 fv, fgray;
    logic [FRAC_BITS:0]   flq, fsq;
    logic [FRAC_BITS-1:0] fhq;

    hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .pix(pixel_in),
        .out_valid(fv), .lq(flq), .sq(fsq), .hq(fhq), .gray(fgray)
    );

    logic          q_ne;
    logic [QW-1:0] q_data;
    hsl_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(fv), .wdata({flq, fsq, fhq}),
        .pop(q_ne), .not_empty(q_ne), .rdata(q_data)
    );

    hsl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_ne),
        .lq(q_data[QW-1 -: FRAC_BITS+1]),
        .sq(q_data[FRAC_BITS*2 -: FRAC_BITS+1]),
        .hq(q_data[FRAC_BITS-1:0]),
        .hue_shift(hue_reg), .sat_offset(sat_reg),
        .done(done), .result(pixel_out)
    );

    `ASSERT_IMP(a_no_busy, clk, rst_n, 1'b1, !busy, "busy raised")
    `ASSERT_NEXT(a_gray_s, clk, rst_n, fv && fgray, 1'b1, "gray check")
    `ASSERT_IMP(a_gray_z, clk, rst_n, fv && fgray, fsq == '0 && fhq == '0, "gray nonzero")
endmodule

@@ dv/testbench.sv @@
module testbench;

    localparam int FRAC = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    hsl_pkg::pixel_in_t pixel_in = '0;
    logic done;
    hsl_pkg::pixel_out_t pixel_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [hsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the configuration
    logic [11:0] hue_shift_reg = '0;
    logic signed [13:0] sat_offset_reg = '0;

    hsl_pkg::pixel_out_t expected_pixels[$];
    int error_count = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int idle_in_pct = 0;
    int stall_cycles = 0;

    hsl_hue_saturation_adjust_unit #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_in(pixel_in), .done(done), .pixel_out(pixel_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Fixed-point channel: ((2*comp + 2m) * 255) >> (F+1), clamped
    function automatic logic [7:0] channel_value(longint comp, longint m2);
        longint v;
        longint q;
        v = (2 * comp + m2) * 255;
        if (v <= 0)
            return 8'd0;
        q = v >>> (FRAC + 1);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic hsl_pkg::pixel_out_t adjust_pixel(hsl_pkg::pixel_in_t px);
        longint one, r, g, b, mx, mn, d, sum, lq, sq, hq, hn, den;
        longint shift, soff, t, cq, h6, u, xq, m2, rc, gc, bc;
        hsl_pkg::pixel_out_t res;
        one = longint'(1) << FRAC;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        mx = r;
        mn = r;
        sq = 0;
        hq = 0;
        rc = 0;
        gc = 0;
        bc = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        lq = sum * one / 510;
        if (d != 0)
        begin
            den = (sum < 255) ? sum : (510 - sum);
            sq = d * one / den;
            if (mx == r)
                hn = (g >= b) ? (g - b) : (6 * d + g - b);
            else if (mx == g)
                hn = 2 * d + b - r;
            else
                hn = 4 * d + r - g;
            hq = hn * one / (6 * d);
        end
        shift = longint'(hue_shift_reg) * one / 4096;
        hq = (hq + shift) & (one - 1);
        // SV division truncates toward zero, as intended
        soff = longint'(sat_offset_reg) * one / 4096;
        sq = sq + soff;
        if (sq < 0) sq = 0;
        if (sq > one) sq = one;
        t = one - abs_l(2 * lq - one);
        cq = (t * sq) / one;
        h6 = hq * 6;
        u = one - abs_l((h6 % (2 * one)) - one);
        xq = (cq * u) / one;
        m2 = 2 * lq - cq;
        case (h6 / one)
            0: begin rc = cq; gc = xq; end
            1: begin rc = xq; gc = cq; end
            2: begin gc = cq; bc = xq; end
            3: begin gc = xq; bc = cq; end
            4: begin rc = xq; bc = cq; end
            default: begin rc = cq; bc = xq; end
        endcase
        res.red_out = channel_value(rc, m2);
        res.green_out = channel_value(gc, m2);
        res.blue_out = channel_value(bc, m2);
        return res;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        hsl_pkg::pixel_out_t exp_px;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result %h", pixel_out);
                error_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                pixels_checked++;
                if (pixel_out.red_out !== exp_px.red_out)
                begin
                    $error("red_out exp %0d got %0d", exp_px.red_out, pixel_out.red_out);
                    error_count++;
                end
                if (pixel_out.green_out !== exp_px.green_out)
                begin
                    $error("green_out exp %0d got %0d", exp_px.green_out,
                           pixel_out.green_out);
                    error_count++;
                end
                if (pixel_out.blue_out !== exp_px.blue_out)
                begin
                    $error("blue_out exp %0d got %0d", exp_px.blue_out, pixel_out.blue_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles outside reset with no request, config write or result accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_valid || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one request, with a random idle gap before it
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        hsl_pkg::pixel_in_t px;
        while ($urandom_range(99, 0) < idle_in_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        px = '{red_in: r, green_in: g, blue_in: b};
        start <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_pixels.push_back(adjust_pixel(px));
        pixels_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [hsl_pkg::CFG_IDX_W-1:0] idx,
                                logic [hsl_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == hsl_pkg::CFG_HUE_SHIFT)
            hue_shift_reg = data[11:0];
        else if (idx == hsl_pkg::CFG_SAT_OFFSET)
            sat_offset_reg = data;
    endtask

    task automatic set_adjust(logic [11:0] hue, logic signed [13:0] sat);
        wait_idle();
        write_config(hsl_pkg::CFG_HUE_SHIFT, {2'b00, hue});
        write_config(hsl_pkg::CFG_SAT_OFFSET, sat);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Extremes, grays, each hue sextant
    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd50, 8'd100);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd85);
    endtask

    task automatic test_config_sweep();
        set_adjust(12'd0, 14'sd4096);
        test_directed();
        set_adjust(12'd4095, -14'sd4096);
        test_directed();
        set_adjust(12'd2048, 14'sd8191);
        test_directed();
        // Most negative offset
        set_adjust(12'd1365, 14'sh2000);
        test_directed();
        set_adjust(12'd700, -14'sd1);
        send_random(100);
    endtask

    // Random pixels under random settings, three idle profiles
    task automatic test_random();
        int pct[3] = '{30, 47, 0};
        for (int p = 0; p < 3; p++)
        begin
            idle_in_pct = pct[p];
            for (int s = 0; s < 4; s++)
            begin
                set_adjust(12'($urandom_range(4095, 0)), 14'($urandom));
                send_random(150);
            end
        end
        // Pause until drained, then resume
        wait_idle();
        send_random(50);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random();
        wait_idle();
        $display("Covered %0d pixels (%0d checked): extremes, grays, all sextants,",
                 pixels_sent, pixels_checked);
        $display("hue shift and saturation offset extremes and random settings.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
